/* rtl/vrst_pkg.sv */
// ----------------------------------------------------------------------------
// vrst_pkg
// Shared constants and types of the resident set tracker.
// ----------------------------------------------------------------------------
package vrst_pkg;

	localparam int FRAMES    = 32;
	localparam int PAGE_BITS = 16;

	localparam int PAGE_W = 16;
	localparam int KEY_W  = (PAGE_BITS < PAGE_W) ? PAGE_BITS : PAGE_W;
	localparam int CNT_W  = $clog2(FRAMES + 1);
	localparam int REG_W  = 16;
	localparam int IDX_W  = 2;
	localparam int RES_W  = 6;

	localparam logic [IDX_W-1:0] REG_MIN_INTERVAL = 2'd0;
	localparam logic [IDX_W-1:0] REG_MAX_INTERVAL = 2'd1;
	localparam logic [IDX_W-1:0] REG_FAULT_LIMIT  = 2'd2;

	localparam logic [REG_W-1:0] MIN_INTERVAL_RST = 16'd10;
	localparam logic [REG_W-1:0] MAX_INTERVAL_RST = 16'd20;
	localparam logic [REG_W-1:0] FAULT_LIMIT_RST  = 16'd11;
	localparam logic [REG_W-1:0] CNT_MAX          = 16'hFFFF;

	typedef logic [KEY_W-1:0] key_t;

	typedef struct packed {
		logic go;
		logic insert;
		logic sample;
	} cell_cmd_t;

	typedef struct packed {
		logic match;
		logic fresh;
		logic valid;
	} cell_stat_t;

	function automatic logic [REG_W-1:0] sat_inc(input logic [REG_W-1:0] v);
		sat_inc = (v == CNT_MAX) ? v : v + 1'b1;
	endfunction

endpackage

/* rtl/vsws_resident_set_tracker.sv */
// ----------------------------------------------------------------------------
// vsws_resident_set_tracker
// Variable-interval sampled working set tracker over a row of frame cells.
//
//   channel  direction  handshake             payload
//   in       request    in_valid / in_stall   page_number
//   out      result     out_valid / out_stall hit, dropped, sampled,
//                                             resident_count
//   cfg      write      cfg_we                cfg_index, cfg_data
//
// One request per cycle while the result is not stalled: a request is held
// in the input register, where it is looked up, updated and sampled across
// all cells. The result register loads from it when processed, so a result
// passes the input register and then the result register; the lookup and
// update in the cell row sets the rate.
// Reset empties the table and clears all four counters; no clearing pass.
// A stalled result holds the input register, which then stalls new requests.
// ----------------------------------------------------------------------------
module vsws_resident_set_tracker
	import vrst_pkg::*;
(
	input  logic              clk,
	input  logic              arst_n,
	input  logic              in_valid,
	output logic              in_stall,
	input  logic [PAGE_W-1:0] page_number,
	output logic              out_valid,
	input  logic              out_stall,
	output logic              hit,
	output logic              dropped,
	output logic              sampled,
	output logic [RES_W-1:0]  resident_count,
	input  logic              cfg_we,
	input  logic [IDX_W-1:0]  cfg_index,
	input  logic [REG_W-1:0]  cfg_data
);

	logic [REG_W-1:0] min_interval_q;
	logic [REG_W-1:0] max_interval_q;
	logic [REG_W-1:0] fault_limit_q;
	logic [REG_W-1:0] elapsed_q;
	logic [REG_W-1:0] fault_q;
	logic [CNT_W-1:0] valid_cnt_q;
	logic [CNT_W-1:0] use_cnt_q;

	logic             busy_q;
	key_t             key_q;
	logic             out_valid_q;
	logic             hit_q;
	logic             dropped_q;
	logic             sampled_q;
	logic [RES_W-1:0] res_q;

	logic             proc;
	logic             in_acc;
	logic [FRAMES:0]  free_chain;
	cell_stat_t       stat [FRAMES];
	logic [FRAMES-1:0] match_vec;
	logic [FRAMES-1:0] fresh_vec;
	logic [FRAMES-1:0] valid_vec;
	cell_cmd_t        cmd;
	logic             hit_any;
	logic             fresh_any;
	logic             full;
	logic             ins;
	logic [REG_W-1:0] elapsed_n;
	logic [REG_W-1:0] fault_n;
	logic             sample;
	logic [CNT_W-1:0] use_n;
	logic [CNT_W-1:0] valid_n;

	// request flow
	assign proc     = busy_q && (!out_valid_q || !out_stall);
	assign in_stall = busy_q && !proc;
	assign in_acc   = in_valid && !in_stall;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q      <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			if (in_acc) begin
				busy_q <= 1'b1;
			end else if (proc) begin
				busy_q <= 1'b0;
			end
			if (proc) begin
				out_valid_q <= 1'b1;
			end else if (!out_stall) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (in_acc) begin
			key_q <= KEY_W'(page_number);
		end
	end

	// configuration
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			min_interval_q <= MIN_INTERVAL_RST;
			max_interval_q <= MAX_INTERVAL_RST;
			fault_limit_q  <= FAULT_LIMIT_RST;
		end else if (cfg_we) begin
			unique case (cfg_index)
				REG_MIN_INTERVAL: min_interval_q <= cfg_data;
				REG_MAX_INTERVAL: max_interval_q <= cfg_data;
				REG_FAULT_LIMIT:  fault_limit_q  <= cfg_data;
				default: ;
			endcase
		end
	end

	// cell row
	assign free_chain[0] = 1'b0;

	for (genvar i = 0; i < FRAMES; i++) begin : g_cell
		vrst_cell u_cell (
			.clk      (clk),
			.arst_n   (arst_n),
			.key      (key_q),
			.cmd      (cmd),
			.free_in  (free_chain[i]),
			.free_out (free_chain[i+1]),
			.stat     (stat[i])
		);
		assign match_vec[i] = stat[i].match;
		assign fresh_vec[i] = stat[i].fresh;
		assign valid_vec[i] = stat[i].valid;
	end

	assign hit_any   = |match_vec;
	assign fresh_any = |fresh_vec;
	assign full      = !free_chain[FRAMES];
	assign ins       = !hit_any && !full;

	// sampling decision
	assign elapsed_n = sat_inc(elapsed_q);
	assign fault_n   = hit_any ? fault_q : sat_inc(fault_q);
	assign sample    = (elapsed_n >= max_interval_q) ||
	                   ((fault_n >= fault_limit_q) && (elapsed_n >= min_interval_q));
	assign use_n     = use_cnt_q + CNT_W'(fresh_any | ins);
	assign valid_n   = valid_cnt_q + CNT_W'(ins);

	assign cmd.go     = proc;
	assign cmd.insert = !hit_any;
	assign cmd.sample = sample;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			elapsed_q   <= '0;
			fault_q     <= '0;
			valid_cnt_q <= '0;
			use_cnt_q   <= '0;
		end else if (proc) begin
			if (sample) begin
				elapsed_q   <= '0;
				fault_q     <= '0;
				valid_cnt_q <= use_n;
				use_cnt_q   <= '0;
			end else begin
				elapsed_q   <= elapsed_n;
				fault_q     <= fault_n;
				valid_cnt_q <= valid_n;
				use_cnt_q   <= use_n;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (proc) begin
			hit_q     <= hit_any;
			dropped_q <= !hit_any && full;
			sampled_q <= sample;
			res_q     <= sample ? RES_W'(use_n) : RES_W'(valid_n);
		end
	end

	assign out_valid      = out_valid_q;
	assign hit            = hit_q;
	assign dropped        = dropped_q;
	assign sampled        = sampled_q;
	assign resident_count = res_q;

	// checks
	a_cnt_matches_row: assert property (@(posedge clk) disable iff (!arst_n)
		valid_cnt_q == CNT_W'($countones(valid_vec)))
		else $error("resident count out of step with frame valid bits");

	a_use_within_valid: assert property (@(posedge clk) disable iff (!arst_n)
		use_cnt_q <= valid_cnt_q)
		else $error("use count exceeds resident count");

	a_single_match: assert property (@(posedge clk) disable iff (!arst_n)
		$onehot0(match_vec))
		else $error("page resident in more than one frame");

	a_sample_clears: assert property (@(posedge clk) disable iff (!arst_n)
		proc && sample |=> elapsed_q == '0 && fault_q == '0 && use_cnt_q == '0)
		else $error("sample did not clear counters");

	a_hit_not_dropped: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid_q |-> !(hit_q && dropped_q))
		else $error("result both hit and dropped");

endmodule

/* rtl/vrst_cell.sv */
// ----------------------------------------------------------------------------
// vrst_cell
// One resident table frame: page tag, valid and use bits, lookup and the
// lowest-free-frame chain link to the next cell.
// ----------------------------------------------------------------------------
module vrst_cell
	import vrst_pkg::*;
(
	input  logic       clk,
	input  logic       arst_n,
	input  key_t       key,
	input  cell_cmd_t  cmd,
	input  logic       free_in,
	output logic       free_out,
	output cell_stat_t stat
);

	key_t page_q;
	logic valid_q;
	logic use_q;
	logic match;
	logic ins_here;
	logic valid_nx;
	logic use_nx;

	assign match    = valid_q && (page_q == key);
	assign free_out = free_in | ~valid_q;
	assign ins_here = cmd.insert & ~free_in & ~valid_q;

	always_comb begin
		use_nx   = use_q | match | ins_here;
		valid_nx = valid_q | ins_here;
		if (cmd.sample) begin
			valid_nx = valid_nx & use_nx;
			use_nx   = 1'b0;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
			use_q   <= 1'b0;
		end else if (cmd.go) begin
			valid_q <= valid_nx;
			use_q   <= use_nx;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.go && ins_here) begin
			page_q <= key;
		end
	end

	assign stat.match = match;
	assign stat.fresh = match & ~use_q;
	assign stat.valid = valid_q;

endmodule
